// ===== rtl/hsl_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl_pkg
// shared types, fixed-point constants and helpers for the hsl to rgb converter
// ----------------------------------------------------------------------------
package hsl_pkg;

    // field widths
    localparam int IN_W  = 16;
    localparam int CH_W  = 8;
    localparam int Q_W   = 21;          // q2.20 value 0 .. 1.0
    localparam int X_W   = 22;          // m1, m2 and spread, a little above 1.0
    localparam int T_W   = 23;          // signed hue argument before wrap
    localparam int OP_W  = 20;          // slope operand, always below 1.0
    localparam int FRAC  = 20;

    localparam logic [Q_W-1:0] Q_ONE   = Q_W'(1) << FRAC;
    localparam logic [Q_W-1:0] Q_THIRD = Q_W'(349525);
    localparam logic [Q_W-1:0] Q_TWO3  = Q_W'(699050);
    localparam logic [CH_W-1:0] CH_MAX = '1;

    // which piece of the hue ramp a channel falls in
    typedef enum logic [1:0] {
        REG_RISE,
        REG_HIGH,
        REG_FALL,
        REG_LOW
    } t_region;

    typedef struct packed {
        t_region          region;
        logic [OP_W-1:0]  op;
    } t_hue_seg;

    // x * 2^20 / 65535, exact floor: 16x + floor(16x / 65535)
    function automatic logic [Q_W-1:0] to_q20(input logic [IN_W-1:0] x);
        logic [19:0] y;
        logic [3:0]  q0;
        logic [16:0] r;
        logic [4:0]  q;
        y  = {x, 4'b0000};
        q0 = y[19:16];
        r  = {1'b0, y[15:0]} + {13'd0, q0};
        q  = {1'b0, q0} + ((r >= 17'd65535) ? 5'd1 : 5'd0);
        return {1'b0, y} + {16'd0, q};
    endfunction

    // wrap a hue argument into 0 .. 1.0 and pick its ramp segment
    function automatic t_hue_seg hue_prep(input logic signed [T_W-1:0] t_in);
        logic signed [T_W-1:0] t_w;
        logic [Q_W-1:0]        t;
        logic [Q_W+2:0]        t6;
        logic [Q_W:0]          t2;
        logic [Q_W+1:0]        t3;
        logic [Q_W-1:0]        diff;
        logic [Q_W+2:0]        d6;
        t_hue_seg              seg;
        t_w = t_in;
        if (t_w < 0) begin
            t_w = t_w + signed'({2'b00, Q_ONE});
        end
        if (t_w > signed'({2'b00, Q_ONE})) begin
            t_w = t_w - signed'({2'b00, Q_ONE});
        end
        t    = t_w[Q_W-1:0];
        t6   = ({3'b000, t} << 2) + ({3'b000, t} << 1);
        t2   = {t, 1'b0};
        t3   = {1'b0, t2} + {2'b00, t};
        diff = Q_TWO3 - t;
        d6   = ({3'b000, diff} << 2) + ({3'b000, diff} << 1);
        if (t6 < {3'b000, Q_ONE}) begin
            seg.region = REG_RISE;
            seg.op     = t6[OP_W-1:0];
        end else if (t2 < {1'b0, Q_ONE}) begin
            seg.region = REG_HIGH;
            seg.op     = '0;
        end else if (t3 < {1'b0, Q_ONE, 1'b0}) begin
            seg.region = REG_FALL;
            seg.op     = d6[OP_W-1:0];
        end else begin
            seg.region = REG_LOW;
            seg.op     = '0;
        end
        return seg;
    endfunction

endpackage

// ===== rtl/hsl_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// streaming hsl to rgb color conversion, six-stage pipeline
// ----------------------------------------------------------------------------
// Takes one color beat per clock while the output is ready (16-bit hue,
// saturation, lightness, each a fraction of 65535) and presents 8-bit red,
// green, blue from the output register of the last stage; one beat per clock
// sustained unless the output stalls. The pipeline stages are: input
// scaling to q2.20, the m2 multiply with hue wrap, m1 and spread, the three
// channel slope multiplies, ramp select, and the scale by 255 into the output
// register. Each stage holds a valid bit and only stalls when the stage after
// it is full and stalled, so bubbles are squeezed out under output backpressure.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,    // hue[15:0], saturation[31:16], lightness[47:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata     // red[7:0], green[15:8], blue[23:16]
);
    import hsl_pkg::*;

    localparam int NSTG = 6;
    localparam int NCH  = 3;

    // stage valid bits and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_load;

    // stage 1: q2.20 inputs
    logic [Q_W-1:0] r_h1, r_s1, r_l1;
    // stage 2: m2 product and hue segments
    logic [Q_W-1:0]   r_s2, r_l2;
    logic             r_lt_half2;
    logic [X_W:0]     r_pq2;
    t_hue_seg         r_seg2 [NCH];
    // stage 3: m2, m1 and spread
    logic [X_W-1:0]   r_hi3, r_lo3, r_d3;
    t_hue_seg         r_seg3 [NCH];
    // stage 4: slope products
    logic [X_W-1:0]   r_hi4, r_lo4;
    logic [X_W-1:0]   r_q4   [NCH];
    t_region          r_reg4 [NCH];
    // stage 5: channel values in q2.20
    logic [X_W:0]     r_v5   [NCH];
    // stage 6: output channels
    logic [CH_W-1:0]  r_ch6  [NCH];

    // load chain: a stage takes new data when empty or when it drains
    always_comb begin
        w_load[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    assign o_s_axis_tready = w_load[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: scale inputs to q2.20
    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_h1 <= to_q20(i_s_axis_tdata[15:0]);
            r_s1 <= to_q20(i_s_axis_tdata[31:16]);
            r_l1 <= to_q20(i_s_axis_tdata[47:32]);
        end
    end

    // stage 2: m2 product and hue wrap per channel
    logic             n_lt_half2;
    logic [X_W-1:0]   n_mb2;
    logic [2*X_W-1:0] n_prod2;
    logic signed [T_W-1:0] n_hs2;

    always_comb begin
        n_lt_half2 = ({r_l1, 1'b0} < {1'b0, Q_ONE});
        n_mb2      = n_lt_half2 ? ({1'b0, Q_ONE} + {1'b0, r_s1}) : {1'b0, r_s1};
        n_prod2    = {{(X_W-Q_W+X_W){1'b0}}, r_l1} * {{X_W{1'b0}}, n_mb2};
        n_hs2      = signed'({2'b00, r_h1});
    end

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r_s2       <= r_s1;
            r_l2       <= r_l1;
            r_lt_half2 <= n_lt_half2;
            r_pq2      <= n_prod2[FRAC +: X_W+1];
            r_seg2[0]  <= hue_prep(n_hs2 + signed'({2'b00, Q_THIRD}));
            r_seg2[1]  <= hue_prep(n_hs2);
            r_seg2[2]  <= hue_prep(n_hs2 - signed'({2'b00, Q_THIRD}));
        end
    end

    // stage 3: m2, m1 clamped at zero, spread clamped at zero
    logic [X_W:0] n_hi3;
    logic [X_W:0] n_l2x3;
    logic [X_W:0] n_lo3;

    always_comb begin
        n_hi3  = r_lt_half2 ? r_pq2 : ({2'b00, r_l2} + {2'b00, r_s2} - r_pq2);
        n_l2x3 = {1'b0, r_l2, 1'b0};
        n_lo3  = (n_l2x3 > n_hi3) ? (n_l2x3 - n_hi3) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r_hi3 <= n_hi3[X_W-1:0];
            r_lo3 <= n_lo3[X_W-1:0];
            r_d3  <= (n_hi3 > n_lo3) ? X_W'(n_hi3 - n_lo3) : '0;
            for (int c = 0; c < NCH; c++) begin
                r_seg3[c] <= r_seg2[c];
            end
        end
    end

    // stage 4: spread times slope operand, one multiplier per channel
    logic [X_W+OP_W-1:0] n_sp4 [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_sp4[c] = {{OP_W{1'b0}}, r_d3} * {{X_W{1'b0}}, r_seg3[c].op};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[3]) begin
            r_hi4 <= r_hi3;
            r_lo4 <= r_lo3;
            for (int c = 0; c < NCH; c++) begin
                r_q4[c]   <= n_sp4[c][FRAC +: X_W];
                r_reg4[c] <= r_seg3[c].region;
            end
        end
    end

    // stage 5: pick the ramp value
    logic [X_W:0] n_v5 [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            case (r_reg4[c])
                REG_RISE: n_v5[c] = {1'b0, r_lo4} + {1'b0, r_q4[c]};
                REG_HIGH: n_v5[c] = {1'b0, r_hi4};
                REG_FALL: n_v5[c] = {1'b0, r_lo4} + {1'b0, r_q4[c]};
                REG_LOW:  n_v5[c] = {1'b0, r_lo4};
                default:  n_v5[c] = {1'b0, r_lo4};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[4]) begin
            for (int c = 0; c < NCH; c++) begin
                r_v5[c] <= n_v5[c];
            end
        end
    end

    // stage 6: scale by 255, truncate, saturate
    logic [X_W+8:0] n_sc6 [NCH];
    logic [X_W-FRAC+8:0] n_c6 [NCH];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_sc6[c] = {r_v5[c], 8'd0} - {8'd0, r_v5[c]};
            n_c6[c]  = n_sc6[c][X_W+8:FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[5]) begin
            for (int c = 0; c < NCH; c++) begin
                r_ch6[c] <= (n_c6[c] > {{(X_W-FRAC+1){1'b0}}, CH_MAX}) ?
                            CH_MAX : n_c6[c][CH_W-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = {r_ch6[2], r_ch6[1], r_ch6[0]};

`ifndef SYNTHESIS
    // input is only held off when every stage is full and the output stalls
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld) && !i_m_axis_tready
    ) else $error("input stalled while the pipeline has room");

    // m2 never falls below m1
    a_hi_not_below_lo: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_hi3 >= r_lo3) && (r_d3 == r_hi3 - r_lo3)
    ) else $error("m2 below m1 or spread wrong");

    // a beat taken into stage five reaches the output stage the next load
    a_beat_moves_on: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && w_load[5] |=> r_vld[5]
    ) else $error("beat lost between ramp select and output");
`endif

endmodule

// ===== tb/hsl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_checker
// watches both stream channels of the hsl to rgb converter, computes the
// expected red, green and blue for every color beat taken in, and compares
// each rgb beat handed out against the oldest pending expectation
// ----------------------------------------------------------------------------
module hsl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_color_tvalid,
    input  logic        i_color_tready,
    input  logic [47:0] i_color_tdata,     // hue[15:0], saturation[31:16], lightness[47:32]
    input  logic        i_rgb_tvalid,
    input  logic        i_rgb_tready,
    input  logic [23:0] i_rgb_tdata,       // red[7:0], green[15:8], blue[23:16]
    output int          o_mismatch_count,
    output int          o_rgb_pending
);

    localparam int IN_W = hsl_pkg::IN_W;
    localparam int CH_W = hsl_pkg::CH_W;

    // q2.20 fixed point, one is 2^20
    localparam longint FX_ONE   = longint'(1) << 20;
    localparam longint FX_THIRD = 349525;
    localparam longint FX_TWO3  = 699050;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    t_rgb expected_rgb[$];

    // 16-bit fraction of 65535 into q2.20, floored
    function automatic longint frac_q20(input logic [IN_W-1:0] x);
        return (longint'(x) << 20) / 65535;
    endfunction

    // truncated q2.20 product, zero for any non-positive operand
    function automatic longint fx_mul(input longint a, input longint b);
        if (a <= 0 || b <= 0) begin
            return 0;
        end
        return (a * b) >>> 20;
    endfunction

    // piecewise hue ramp between the low and high levels
    function automatic longint ramp_level(input longint lo, input longint hi, input longint t);
        longint spread;
        longint tw;
        spread = hi - lo;
        if (spread < 0) begin
            spread = 0;
        end
        tw = t;
        if (tw < 0) begin
            tw = tw + FX_ONE;
        end
        if (tw > FX_ONE) begin
            tw = tw - FX_ONE;
        end
        if (6 * tw < FX_ONE) begin
            return lo + fx_mul(spread, 6 * tw);
        end
        if (2 * tw < FX_ONE) begin
            return hi;
        end
        if (3 * tw < 2 * FX_ONE) begin
            return lo + fx_mul(spread, 6 * (FX_TWO3 - tw));
        end
        return lo;
    endfunction

    // scale by 255, truncate and saturate
    function automatic logic [CH_W-1:0] level_to_channel(input longint v);
        longint c;
        if (v <= 0) begin
            return '0;
        end
        c = (v * 255) >>> 20;
        if (c > 255) begin
            c = 255;
        end
        return c[CH_W-1:0];
    endfunction

    // full conversion of one color beat
    function automatic t_rgb rgb_of_hsl(input logic [47:0] beat);
        longint hq;
        longint sq;
        longint lq;
        longint hi;
        longint lo;
        t_rgb   rgb;
        hq = frac_q20(beat[15:0]);
        sq = frac_q20(beat[31:16]);
        lq = frac_q20(beat[47:32]);
        if (beat[31:16] == '0) begin
            // grey
            rgb.red   = level_to_channel(lq);
            rgb.green = rgb.red;
            rgb.blue  = rgb.red;
            return rgb;
        end
        if (2 * lq < FX_ONE) begin
            hi = fx_mul(lq, FX_ONE + sq);
        end else begin
            hi = lq + sq - fx_mul(lq, sq);
        end
        lo = 2 * lq - hi;
        if (lo < 0) begin
            lo = 0;
        end
        rgb.red   = level_to_channel(ramp_level(lo, hi, hq + FX_THIRD));
        rgb.green = level_to_channel(ramp_level(lo, hi, hq));
        rgb.blue  = level_to_channel(ramp_level(lo, hi, hq - FX_THIRD));
        return rgb;
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        o_mismatch_count = o_mismatch_count + 1;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // compare one channel of an rgb beat
    task automatic check_channel(input string name, input logic [CH_W-1:0] got,
                                 input logic [CH_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // track color beats in and rgb beats out
    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            expected_rgb.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_rgb_tvalid && i_rgb_tready) begin
                got = i_rgb_tdata;
                if (expected_rgb.size() == 0) begin
                    report_mismatch($sformatf("rgb beat %h with no color pending", got));
                end else begin
                    want = expected_rgb.pop_front();
                    check_channel("red", got.red, want.red);
                    check_channel("green", got.green, want.green);
                    check_channel("blue", got.blue, want.blue);
                end
            end
            if (i_color_tvalid && i_color_tready) begin
                expected_rgb.push_back(rgb_of_hsl(i_color_tdata));
            end
        end
        o_rgb_pending = expected_rgb.size();
    end

endmodule

// ===== tb/tb_hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_converter
// drives color beats into the converter in random bursts while the rgb side
// stalls on its own pattern; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter;

    localparam int N_RANDOM = 450;
    localparam int DRAIN    = 16;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        color_valid = 1'b0;
    logic        color_ready;
    logic [47:0] color_data  = '0;      // hue[15:0], saturation[31:16], lightness[47:32]
    logic        rgb_valid;
    logic        rgb_ready   = 1'b1;
    logic [23:0] rgb_data;              // red[7:0], green[15:8], blue[23:16]
    int          mismatch_count;
    int          rgb_pending;

    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    logic [7:0] stall_pattern = 8'b1011_0010;

    hsl_to_rgb_converter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (color_valid),
        .o_s_axis_tready (color_ready),
        .i_s_axis_tdata  (color_data),
        .o_m_axis_tvalid (rgb_valid),
        .i_m_axis_tready (rgb_ready),
        .o_m_axis_tdata  (rgb_data)
    );

    hsl_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_color_tvalid   (color_valid),
        .i_color_tready   (color_ready),
        .i_color_tdata    (color_data),
        .i_rgb_tvalid     (rgb_valid),
        .i_rgb_tready     (rgb_ready),
        .i_rgb_tdata      (rgb_data),
        .o_mismatch_count (mismatch_count),
        .o_rgb_pending    (rgb_pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // rgb side backpressure: free-running, random, heavy stall, rotating pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(4, 60);
        end
        stall_left = stall_left - 1;
        stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
        case (stall_mode)
            0: begin
                rgb_ready <= 1'b1;
            end
            1: begin
                rgb_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                rgb_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                rgb_ready <= stall_pattern[0];
            end
        endcase
    end

    // one color beat, with a random gap before each new burst
    task automatic send_color(input logic [15:0] hue, input logic [15:0] sat,
                              input logic [15:0] lit);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                color_valid <= 1'b0;
            end
        end
        burst_left = burst_left - 1;
        @(negedge i_clk);
        color_valid <= 1'b1;
        color_data  <= {lit, sat, hue};
        @(posedge i_clk);
        while (!color_ready) begin
            @(posedge i_clk);
        end
    endtask

    // hue close to a sixth of the circle, where the ramp changes piece
    function automatic logic [15:0] hue_near_sixth();
        int h;
        h = ($urandom_range(0, 6) * 65535) / 6 + $urandom_range(0, 6) - 3;
        if (h < 0) begin
            h = 0;
        end
        if (h > 65535) begin
            h = 65535;
        end
        return h[15:0];
    endfunction

    // lightness at the ends or around one half
    function automatic logic [15:0] lit_near_edge();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'($urandom_range(32764, 32771));
            default: return 16'($urandom_range(65532, 65535));
        endcase
    endfunction

    // stimulus
    initial begin
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] lit;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and grey
        send_color(16'h0000, 16'h0000, 16'h0000);
        send_color(16'hffff, 16'hffff, 16'hffff);
        send_color(16'h1234, 16'h0000, 16'hffff);
        send_color(16'h8000, 16'h0000, 16'h8000);
        send_color(16'hffff, 16'h0000, 16'h7fff);
        // lightness on either side of one half
        send_color(16'h2000, 16'hffff, 16'h7fff);
        send_color(16'h2000, 16'hffff, 16'h8000);
        send_color(16'h2000, 16'h0001, 16'h8000);
        // hue at each piece boundary, full circle same as zero
        send_color(16'd0,     16'hffff, 16'h8000);
        send_color(16'd65535, 16'hffff, 16'h8000);
        send_color(16'd10922, 16'hffff, 16'h8000);
        send_color(16'd10923, 16'hffff, 16'h8000);
        send_color(16'd21845, 16'hffff, 16'h8000);
        send_color(16'd21846, 16'hffff, 16'h8000);
        send_color(16'd32767, 16'hffff, 16'h8000);
        send_color(16'd32768, 16'hffff, 16'h8000);
        send_color(16'd43690, 16'hffff, 16'h8000);
        send_color(16'd43691, 16'hffff, 16'h8000);
        send_color(16'd54612, 16'hffff, 16'h8000);
        send_color(16'd54613, 16'hffff, 16'h8000);
        // saturated channel near full scale, tiny and toggling fields
        send_color(16'h0000, 16'hffff, 16'hfffe);
        send_color(16'haaaa, 16'h5555, 16'haaaa);
        send_color(16'h5555, 16'haaaa, 16'h5555);
        send_color(16'h0001, 16'h0001, 16'h0001);

        // random colors, weighted toward the corners of the rule
        repeat (N_RANDOM) begin
            hue = 16'($urandom_range(0, 65535));
            sat = 16'($urandom_range(0, 65535));
            lit = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 9))
                0: sat = '0;
                1, 2: hue = hue_near_sixth();
                3: lit = lit_near_edge();
                4: begin
                    sat = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0001;
                    hue = hue_near_sixth();
                end
                default: ;
            endcase
            send_color(hue, sat, lit);
        end
        @(negedge i_clk);
        color_valid <= 1'b0;

        // drain until no rgb beat is pending, then idle before finishing
        while (rgb_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
